// File: hdl/mtet_pkg.sv
package mtet_pkg;

  // Width of the running byte offset; the counter saturates at all ones
  localparam int unsigned OffsetBits = 24;

  // Width of the span fields on the result channel
  localparam int unsigned SpanBits = 24;

  // Characters that drive the parser
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNewline = 8'h0A;

  typedef enum logic [1:0] {
    EvEntity = 2'd0,
    EvKey    = 2'd1,
    EvValue  = 2'd2,
    EvBrush  = 2'd3
  } event_kind_e;

  // One parser event as handed from the parser to the result register
  typedef struct packed {
    event_kind_e          kind;
    logic [SpanBits-1:0]  start;
    logic [SpanBits-1:0]  length;
  } event_t;

endpackage

// File: hdl/mtet_parser.sv
module mtet_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic [7:0]      text_byte_i,
  input  logic            start_of_text_i,
  output logic            emit_o,
  output mtet_pkg::event_t event_o
);

  typedef enum logic [2:0] {
    ModeDefault = 3'd0,
    ModeSlash   = 3'd1,
    ModeEntity  = 3'd2,
    ModeAwait   = 3'd3,
    ModeKey     = 3'd4,
    ModeValue   = 3'd5,
    ModeBrushes = 3'd6,
    ModeComment = 3'd7
  } mode_e;

  localparam int unsigned OffW = mtet_pkg::OffsetBits;
  localparam int unsigned ExtW = mtet_pkg::OffsetBits + mtet_pkg::SpanBits;
  localparam logic [OffW-1:0] OffMax = {OffW{1'b1}};

  mode_e           mode_q, mode_d;
  logic [OffW-1:0] offset_q, offset_d;
  logic [OffW-1:0] begin_q, begin_d;

  mode_e           mode_cur;
  logic [OffW-1:0] pos;
  logic [OffW-1:0] begin_cur;
  logic [OffW-1:0] pos_inc;
  logic [OffW-1:0] span_len;
  logic [ExtW-1:0] pos_ext;
  logic [ExtW-1:0] begin_ext;
  logic [ExtW-1:0] len_ext;
  logic            emit;
  logic            emit_entity;
  mtet_pkg::event_kind_e kind;

  // Start of text clears the state before the byte is handled
  always_comb begin
    mode_cur  = start_of_text_i ? ModeDefault : mode_q;
    pos       = start_of_text_i ? '0 : offset_q;
    begin_cur = start_of_text_i ? '0 : begin_q;
  end

  // Saturating increment and span length
  assign pos_inc  = (pos == OffMax) ? OffMax : pos + OffW'(1);
  assign span_len = (pos >= begin_cur) ? pos - begin_cur : '0;

  // Widen, then keep the low span bits
  assign pos_ext   = ExtW'(pos);
  assign begin_ext = ExtW'(begin_cur);
  assign len_ext   = ExtW'(span_len);

  // Mode transitions and event selection
  always_comb begin
    mode_d      = mode_cur;
    begin_d     = begin_cur;
    emit        = 1'b0;
    emit_entity = 1'b0;
    kind        = mtet_pkg::EvEntity;
    unique case (mode_cur)
      ModeDefault, ModeSlash: begin
        if (mode_cur == ModeSlash && text_byte_i == mtet_pkg::ChSlash) begin
          mode_d = ModeComment;
        end else if (text_byte_i == mtet_pkg::ChSlash) begin
          mode_d = ModeSlash;
        end else if (text_byte_i == mtet_pkg::ChLBrace) begin
          mode_d      = ModeEntity;
          emit        = 1'b1;
          emit_entity = 1'b1;
          kind        = mtet_pkg::EvEntity;
        end else begin
          mode_d = ModeDefault;
        end
      end
      ModeEntity: begin
        if (text_byte_i == mtet_pkg::ChQuote) begin
          mode_d  = ModeKey;
          begin_d = pos_inc;
        end else if (text_byte_i == mtet_pkg::ChLBrace) begin
          mode_d  = ModeBrushes;
          begin_d = pos_inc;
        end else if (text_byte_i == mtet_pkg::ChRBrace) begin
          mode_d = ModeDefault;
        end
      end
      ModeAwait: begin
        if (text_byte_i == mtet_pkg::ChQuote) begin
          mode_d  = ModeValue;
          begin_d = pos_inc;
        end
      end
      ModeKey: begin
        if (text_byte_i == mtet_pkg::ChQuote) begin
          mode_d = ModeAwait;
          emit   = 1'b1;
          kind   = mtet_pkg::EvKey;
        end
      end
      ModeValue: begin
        if (text_byte_i == mtet_pkg::ChQuote) begin
          mode_d = ModeEntity;
          emit   = 1'b1;
          kind   = mtet_pkg::EvValue;
        end
      end
      ModeBrushes: begin
        if (text_byte_i == mtet_pkg::ChRBrace) begin
          mode_d = ModeEntity;
          emit   = 1'b1;
          kind   = mtet_pkg::EvBrush;
        end
      end
      ModeComment: begin
        if (text_byte_i == mtet_pkg::ChNewline) begin
          mode_d = ModeDefault;
        end
      end
      default: mode_d = ModeComment;
    endcase
    offset_d = pos_inc;
  end

  // Build the event
  always_comb begin
    event_o.kind = kind;
    if (emit_entity) begin
      event_o.start  = pos_ext[mtet_pkg::SpanBits-1:0];
      event_o.length = '0;
    end else begin
      event_o.start  = begin_ext[mtet_pkg::SpanBits-1:0];
      event_o.length = len_ext[mtet_pkg::SpanBits-1:0];
    end
  end

  assign emit_o = emit;

  // Hold parser state; advance once per handled byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeDefault;
      offset_q <= '0;
      begin_q  <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      offset_q <= offset_d;
      begin_q  <= begin_d;
    end
  end

`ifndef NO_ASSERTIONS
  // An open span never starts past the next byte offset
  a_begin_le_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    begin_q <= offset_q)
    else $error("span begin ahead of byte offset");

  // The offset only moves forward unless the text restarts
  a_offset_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && !start_of_text_i |=> offset_q >= $past(offset_q))
    else $error("byte offset went backwards");

  // Entity begin events carry no length
  a_entity_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && kind == mtet_pkg::EvEntity |-> event_o.length == '0)
    else $error("entity begin with non-zero length");
`endif

endmodule

// File: hdl/map_text_entity_tokenizer.sv
// Channel   Dir  tdata                                   tuser
// s_axis    in   [7:0] text_byte                         [0] start_of_text
// m_axis    out  [23:0] span_start, [47:24] span_length  [1:0] event_kind
//
// One byte is taken every cycle unless the result register stalls; each byte
// passes the input register and, if it raises an event, the result register.
// The mode transition and one offset subtraction sit between the two.
// Reset clears parser mode, offsets and both valid flags.
// A stalled result register holds the input register, which then drops tready.
module map_text_entity_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] start_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] span_start, [47:24] span_length
  output logic [1:0]  m_axis_tuser    // [1:0] event_kind
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_sot_q;
  logic             out_valid_q;
  mtet_pkg::event_t out_event_q;
  logic             advance;
  logic             emit;
  mtet_pkg::event_t event_cur;

  // Move a byte on when the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Hold the input request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_sot_q  <= s_axis_tuser;
    end
  end

  mtet_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .text_byte_i     (in_byte_q),
    .start_of_text_i (in_sot_q),
    .emit_o          (emit),
    .event_o         (event_cur)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_event_q <= event_cur;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_event_q.length, out_event_q.start};
  assign m_axis_tuser  = out_event_q.kind;

endmodule

// File: tb/sv/span_event_checker.sv
// Watches both stream channels of the map text tokenizer, tracks the parser
// state for every accepted byte and checks each emitted span event in order.
module span_event_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tuser,   // [0] start_of_text
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [23:0] span_start, [47:24] span_length
  input  logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned OffW  = mtet_pkg::OffsetBits;
  localparam int unsigned SpanW = mtet_pkg::SpanBits;

  typedef enum logic [2:0] {
    ModeText    = 3'd0,
    ModeSlash   = 3'd1,
    ModeEntity  = 3'd2,
    ModeAwait   = 3'd3,
    ModeKey     = 3'd4,
    ModeValue   = 3'd5,
    ModeBrushes = 3'd6,
    ModeComment = 3'd7
  } parse_mode_e;

  parse_mode_e           mode_q;
  logic [OffW-1:0]       offset_q;
  logic [OffW-1:0]       span_open_q;
  mtet_pkg::event_t      span_events_q[$];
  int unsigned           errors;

  function automatic logic [OffW-1:0] offset_inc(input logic [OffW-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Advance the parser by one byte and queue the event it raises, if any
  task automatic predict_map_byte(input logic [7:0] ch, input logic sot);
    logic [OffW-1:0]  pos;
    logic [OffW-1:0]  span_len;
    logic             as_text;
    logic             hit;
    mtet_pkg::event_t ev;
    if (sot) begin
      mode_q      = ModeText;
      offset_q    = '0;
      span_open_q = '0;
    end
    pos      = offset_q;
    span_len = (pos >= span_open_q) ? pos - span_open_q : '0;
    as_text  = 1'b0;
    hit      = 1'b0;
    ev       = '0;
    case (mode_q)
      ModeText: as_text = 1'b1;
      ModeSlash: begin
        if (ch == mtet_pkg::ChSlash) mode_q = ModeComment;
        else as_text = 1'b1;
      end
      ModeEntity: begin
        if (ch == mtet_pkg::ChQuote) begin
          mode_q      = ModeKey;
          span_open_q = offset_inc(pos);
        end else if (ch == mtet_pkg::ChLBrace) begin
          mode_q      = ModeBrushes;
          span_open_q = offset_inc(pos);
        end else if (ch == mtet_pkg::ChRBrace) begin
          mode_q = ModeText;
        end
      end
      ModeAwait: begin
        if (ch == mtet_pkg::ChQuote) begin
          mode_q      = ModeValue;
          span_open_q = offset_inc(pos);
        end
      end
      ModeKey: begin
        if (ch == mtet_pkg::ChQuote) begin
          mode_q  = ModeAwait;
          hit     = 1'b1;
          ev.kind = mtet_pkg::EvKey;
        end
      end
      ModeValue: begin
        if (ch == mtet_pkg::ChQuote) begin
          mode_q  = ModeEntity;
          hit     = 1'b1;
          ev.kind = mtet_pkg::EvValue;
        end
      end
      ModeBrushes: begin
        if (ch == mtet_pkg::ChRBrace) begin
          mode_q  = ModeEntity;
          hit     = 1'b1;
          ev.kind = mtet_pkg::EvBrush;
        end
      end
      default: begin
        if (ch == mtet_pkg::ChNewline) mode_q = ModeText;
      end
    endcase
    if (hit) begin
      ev.start  = span_open_q;
      ev.length = span_len;
    end
    // a byte after a lone slash is handled as plain text
    if (as_text) begin
      if (ch == mtet_pkg::ChSlash) begin
        mode_q = ModeSlash;
      end else if (ch == mtet_pkg::ChLBrace) begin
        mode_q    = ModeEntity;
        hit       = 1'b1;
        ev.kind   = mtet_pkg::EvEntity;
        ev.start  = pos;
        ev.length = '0;
      end else begin
        mode_q = ModeText;
      end
    end
    if (hit) span_events_q.insert(span_events_q.size(), ev);
    offset_q = offset_inc(pos);
  endtask

  task automatic report_field(input string field, input logic [SpanW-1:0] want,
                              input logic [SpanW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Check results before taking new bytes: a result never comes from the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    mtet_pkg::event_t want_ev;
    if (!rst_ni) begin
      mode_q       = ModeText;
      offset_q     = '0;
      span_open_q  = '0;
      errors       = 0;
      span_events_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (span_events_q.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual kind %0d start %0d length %0d",
                   $time, m_axis_tuser, m_axis_tdata[SpanW-1:0],
                   m_axis_tdata[2*SpanW-1:SpanW]);
          errors++;
        end else begin
          want_ev = span_events_q.pop_front();
          report_field("event_kind", want_ev.kind, m_axis_tuser);
          report_field("span_start", want_ev.start, m_axis_tdata[SpanW-1:0]);
          report_field("span_length", want_ev.length, m_axis_tdata[2*SpanW-1:SpanW]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_map_byte(s_axis_tdata, s_axis_tuser);
      fail_count_o <= errors;
      pending_o    <= span_events_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

  typedef struct packed {
    logic       sot;
    logic [7:0] ch;
  } text_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending_events;

  text_item_t  map_text_q[$];
  logic        restart_next = 1'b0;
  logic        send_busy_phase = 1'b0;
  logic        recv_busy_phase = 1'b0;
  int unsigned gap;
  int unsigned stall;
  int unsigned events_taken = 0;

  map_text_entity_tokenizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  span_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_events)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Queue one byte; a pending restart marks it as start of text
  task automatic push_byte(input logic [7:0] ch);
    map_text_q.insert(map_text_q.size(), text_item_t'{sot: restart_next, ch: ch});
    restart_next = 1'b0;
  endtask

  // Random span contents that never contain the closing character
  task automatic push_body(input logic [7:0] stop);
    int unsigned len;
    logic [7:0]  ch;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      ch = 8'($urandom_range(0, 255));
      if (ch == stop) ch = ch ^ 8'h01;
      push_byte(ch);
    end
  endtask

  // One entity with key/value pairs and brush blocks; sometimes cut short
  task automatic push_entity();
    int unsigned pairs;
    push_byte(mtet_pkg::ChLBrace);
    pairs = $urandom_range(0, 3);
    for (int i = 0; i < pairs; i++) begin
      if ($urandom_range(0, 1) == 0) push_byte(mtet_pkg::ChNewline);
      if ($urandom_range(0, 4) == 0) begin
        push_byte(mtet_pkg::ChLBrace);
        push_body(mtet_pkg::ChRBrace);
        push_byte(mtet_pkg::ChRBrace);
      end else begin
        push_byte(mtet_pkg::ChQuote);
        push_body(mtet_pkg::ChQuote);
        push_byte(mtet_pkg::ChQuote);
        if ($urandom_range(0, 1) == 0) push_byte(8'h20);
        if ($urandom_range(0, 7) == 0) push_body(mtet_pkg::ChQuote);
        push_byte(mtet_pkg::ChQuote);
        if ($urandom_range(0, 12) != 0) begin
          push_body(mtet_pkg::ChQuote);
          push_byte(mtet_pkg::ChQuote);
        end
      end
      if ($urandom_range(0, 15) == 0) return;
    end
    push_byte(mtet_pkg::ChRBrace);
    push_byte(mtet_pkg::ChNewline);
  endtask

  // Line comment, possibly holding braces and quotes
  task automatic push_comment();
    push_byte(mtet_pkg::ChSlash);
    push_byte(mtet_pkg::ChSlash);
    push_body(mtet_pkg::ChNewline);
    if ($urandom_range(0, 9) != 0) push_byte(mtet_pkg::ChNewline);
  endtask

  task automatic build_map_text();
    // directed: byte extremes, lone slash, slash before brace, empty key,
    // ignored byte while awaiting a value, brush block, comment, restarts
    restart_next = 1'b1;
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(mtet_pkg::ChSlash);
    push_byte(8'h78);
    push_byte(mtet_pkg::ChSlash);
    push_byte(mtet_pkg::ChLBrace);
    push_byte(mtet_pkg::ChQuote);
    push_byte(mtet_pkg::ChQuote);
    push_byte(8'h78);
    push_byte(mtet_pkg::ChQuote);
    push_byte(8'h61);
    push_byte(mtet_pkg::ChQuote);
    push_byte(mtet_pkg::ChLBrace);
    push_byte(mtet_pkg::ChRBrace);
    push_byte(mtet_pkg::ChRBrace);
    push_byte(mtet_pkg::ChSlash);
    push_byte(mtet_pkg::ChSlash);
    push_byte(mtet_pkg::ChLBrace);
    push_byte(mtet_pkg::ChNewline);
    push_byte(mtet_pkg::ChLBrace);
    restart_next = 1'b1;
    push_byte(mtet_pkg::ChLBrace);
    push_byte(mtet_pkg::ChRBrace);
    // random: mostly well-formed entities, some comments, noise and restarts
    while (map_text_q.size() < 1620) begin
      if ($urandom_range(0, 40) == 0) restart_next = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_entity();
        6: push_comment();
        7: begin
          for (int i = 0; i < $urandom_range(1, 6); i++) push_byte(8'($urandom_range(0, 255)));
        end
        8: push_byte(mtet_pkg::ChNewline);
        default: begin
          push_byte(mtet_pkg::ChSlash);
          push_byte($urandom_range(0, 3) == 0 ? mtet_pkg::ChLBrace : 8'h20);
        end
      endcase
    end
  endtask

  // Send the map text, then wait for every event and give the verdict
  initial begin
    build_map_text();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (map_text_q[i]) begin
      if (i % 128 == 0) send_busy_phase = ($urandom_range(0, 2) != 0);
      gap = send_busy_phase ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= map_text_q[i].ch;
      s_axis_tuser  <= map_text_q[i].sot;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_events != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending_events == 0) begin
      $display("map_text_entity_tokenizer test passed");
    end else begin
      $display("map_text_entity_tokenizer test failed");
    end
    $finish;
  end

  // Accept events with random stalls; hold off once for long enough to fill the block
  initial begin
    @(posedge rst_ni);
    forever begin
      if (events_taken % 64 == 0) recv_busy_phase = ($urandom_range(0, 2) != 0);
      stall = recv_busy_phase ? $urandom_range(0, 17) : 0;
      if (events_taken == 60) stall = 400;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      events_taken++;
    end
  end

  initial begin
    #2000000;
    $display("map_text_entity_tokenizer test failed");
    $finish;
  end

endmodule

// File: map_text_entity_tokenizer.f
hdl/mtet_pkg.sv
hdl/mtet_parser.sv
hdl/map_text_entity_tokenizer.sv
tb/sv/span_event_checker.sv
tb/sv/tb_top.sv
